@@ hdl/srwf_pkg.sv @@
// Shared types and constants of the session replay window filter.
// Used by srwf_check and session_replay_window_filter; depends on nothing.
package srwf_pkg;

  // Width of the sliding counter window, from 1 to 64.
  localparam int WINDOW_BITS = 64;
  // Bits needed to address one position of the window.
  localparam int SH_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

  localparam logic [7:0]  HDR_MIC_BYTES = 8'd12;
  localparam logic [31:0] WINDOW_SPAN   = 32'(WINDOW_BITS);

  typedef enum logic [2:0] {
    ST_ACCEPT      = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_MIC     = 3'd2,
    ST_OLD_SESSION = 3'd3,
    ST_REPLAY      = 3'd4
  } srwf_status_e;

  typedef struct packed {
    logic [7:0]  frame_length;
    logic [31:0] session_tag;
    logic [31:0] counter;
    logic        mic_ok;
  } srwf_item_t;

  typedef struct packed {
    srwf_status_e status;
    logic [7:0]   payload_length;
    logic         started_session;
  } srwf_result_t;

  typedef struct packed {
    logic [31:0]            session;
    logic                   known;
    logic [31:0]            highest;
    logic [WINDOW_BITS-1:0] bitmap;
  } srwf_state_t;

endpackage

@@ hdl/srwf_check.sv @@
// Frame verdict and replay window update for one frame header.
// Pure combinational logic; depends on srwf_pkg.
module srwf_check import srwf_pkg::*; (
  input  srwf_item_t   item_i,
  input  srwf_state_t  state_i,
  output srwf_state_t  state_o,
  output srwf_result_t result_o
);

  logic [31:0]   delta;
  logic [31:0]   dist_up;
  logic [31:0]   dist_dn;
  logic          ahead;
  logic [SH_W-1:0] sh_up;
  logic [SH_W-1:0] sh_dn;
  logic [WINDOW_BITS-1:0] dn_bit;
  srwf_status_e  status;

  assign delta   = item_i.session_tag - state_i.session;
  assign ahead   = item_i.counter > state_i.highest;
  assign dist_up = item_i.counter - state_i.highest;
  assign dist_dn = state_i.highest - item_i.counter;
  assign sh_up   = dist_up[SH_W-1:0];
  assign sh_dn   = dist_dn[SH_W-1:0];
  assign dn_bit  = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << sh_dn;

  always_comb begin
    state_o  = state_i;
    status   = ST_ACCEPT;
    result_o.started_session = 1'b0;
    if (item_i.frame_length <= HDR_MIC_BYTES) begin
      status = ST_SHORT;
    end else if (!item_i.mic_ok) begin
      status = ST_BAD_MIC;
    end else if (!state_i.known || (item_i.session_tag != state_i.session)) begin
      // A nonzero delta with the sign bit set, half the range included, is an older session.
      if (state_i.known && delta[31]) begin
        status = ST_OLD_SESSION;
      end else begin
        state_o.session = item_i.session_tag;
        state_o.known   = 1'b1;
        state_o.highest = item_i.counter;
        state_o.bitmap  = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
        result_o.started_session = 1'b1;
      end
    end else if (ahead) begin
      // The window slides forward; a large jump leaves only the newest counter marked.
      if (dist_up >= WINDOW_SPAN) begin
        state_o.bitmap = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
      end else begin
        state_o.bitmap = (state_i.bitmap << sh_up) | {{(WINDOW_BITS-1){1'b0}}, 1'b1};
      end
      state_o.highest = item_i.counter;
    end else if ((dist_dn >= WINDOW_SPAN) || ((state_i.bitmap & dn_bit) != '0)) begin
      status = ST_REPLAY;
    end else begin
      state_o.bitmap = state_i.bitmap | dn_bit;
    end
    result_o.status = status;
    result_o.payload_length = (status == ST_ACCEPT) ?
                              (item_i.frame_length - HDR_MIC_BYTES) : 8'd0;
  end

endmodule

@@ hdl/session_replay_window_filter.sv @@
// Top level of the session replay window filter: input register, verdict logic
// and result register. Depends on srwf_pkg and srwf_check.
//
// Usage: each frame header enters as one transaction on the s_axis channel and
// leaves exactly one verdict transaction on the m_axis channel, in order.
// The verdict says whether the frame is accepted, too short, failed its MIC,
// belongs to an older session, or carries a replayed or stale counter.
// A frame with a newer session id opens that session and restarts the window.
//
// A transaction is taken into the input register, judged against the session and
// window state, and its verdict is registered in the output register. Throughput
// is one transaction per cycle while the receiver does not stall; the limit is the
// combinational state update (compare, subtract and window barrel shift) that each
// frame needs before the next is judged.
//
// Reset clears the session, the window and the valid flags of both pipeline
// registers. When the receiver stalls, the verdict waits in the output register
// and the frame held in the input register waits behind it; s_axis_tready drops
// only once both are occupied, and no transaction is lost.
module session_replay_window_filter import srwf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] frame_length, [39:8] session_tag, [71:40] counter
  input  logic [71:0] s_axis_tdata,
  // [0] mic_ok
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [10:3] payload_length, [15:11] zero
  output logic [15:0] m_axis_tdata,
  // [0] started_session
  output logic        m_axis_tuser
);

  logic         in_vld_q, in_vld_d;
  srwf_item_t   in_q, in_d;
  logic         out_vld_q, out_vld_d;
  srwf_result_t out_q, out_d;
  srwf_state_t  state_q, state_d;
  srwf_state_t  state_nx;
  srwf_result_t result;
  logic         adv;
  logic         take;

  // The judged frame moves on when the result register is free or being drained.
  assign adv  = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign take = s_axis_tvalid && s_axis_tready;

  srwf_check u_check (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_nx),
    .result_o (result)
  );

  always_comb begin
    in_vld_d  = take ? 1'b1 : (adv ? 1'b0 : in_vld_q);
    in_d      = in_q;
    if (take) begin
      in_d.frame_length = s_axis_tdata[7:0];
      in_d.session_tag  = s_axis_tdata[39:8];
      in_d.counter      = s_axis_tdata[71:40];
      in_d.mic_ok       = s_axis_tuser;
    end
    out_vld_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);
    out_d     = adv ? result : out_q;
    state_d   = adv ? state_nx : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q.payload_length, out_q.status};
  assign m_axis_tuser  = out_q.started_session;

  // A rejected frame must leave the session and window untouched.
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (result.status != ST_ACCEPT) |=> state_q == $past(state_q))
    else $error("rejected frame changed filter state");

  // Opening a session leaves only the newest counter marked.
  a_new_session_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && result.started_session |=>
      state_q.known && (state_q.bitmap == {{(WINDOW_BITS-1){1'b0}}, 1'b1}))
    else $error("new session did not restart the window");

  // Any accepted frame leaves the highest counter marked as seen.
  a_accept_marks_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (result.status == ST_ACCEPT) |=> state_q.bitmap[0])
    else $error("accepted frame left highest counter unmarked");

  // Once a session is known it stays known until reset.
  a_known_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.known |=> state_q.known)
    else $error("session knowledge was lost");

endmodule
